// ===== rtl/core/nds_pkg.sv =====
// Shared types, constants and arithmetic helpers for the normal distribution unit.
// Used by every module under rtl/core; depends on nothing else.
package nds_pkg;

    // Default saturation width of the result.
    localparam int DATA_WIDTH_DEF = 32;

    // Queue between the front and the evaluation lanes.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    // Operation codes.
    localparam logic [1:0] OP_DENSITY  = 2'd0;
    localparam logic [1:0] OP_CDF      = 2'd1;
    localparam logic [1:0] OP_INTERVAL = 2'd2;

    // Configuration register indexes.
    localparam logic REG_MEAN    = 1'b0;
    localparam logic REG_STD_DEV = 1'b1;

    localparam logic [31:0] STD_DEV_RESET = 32'd65536;

    // Fixed-point constants.
    localparam logic [31:0] INV_SQRT2_Q32   = 32'd3037000500;
    localparam logic [31:0] INV_SQRT2PI_Q32 = 32'd1713444048;
    localparam logic [31:0] P_Q32           = 32'd1406993061;
    localparam logic [31:0] LN2_Q32         = 32'd2977044472;
    localparam logic [39:0] LN2_X64         = 40'd190530846208;
    localparam logic [29:0] Z_CLAMP_Q24     = 30'd268435456;

    localparam logic signed [33:0] A1_Q30 = 34'sd273621191;
    localparam logic signed [33:0] A2_Q30 = -34'sd305476044;
    localparam logic signed [33:0] A3_Q30 = 34'sd1526231383;
    localparam logic signed [33:0] A4_Q30 = -34'sd1560310108;
    localparam logic signed [33:0] A5_Q30 = 34'sd1139675401;

    // Input and result words.
    typedef struct packed {
        logic [1:0]          operation;
        logic signed [31:0]  x_or_lower;
        logic signed [31:0]  upper_bound;
        logic                last_in;
    } nds_in_t;

    typedef struct packed {
        logic signed [31:0]  value;
        logic                last_out;
    } nds_out_t;

    // Per-word side information that travels with the evaluation.
    typedef struct packed {
        logic [1:0] op;
        logic       last;
    } nds_tag_t;

    // One classified operand: sign and magnitude of the distance to the mean.
    typedef struct packed {
        logic        neg;
        logic [32:0] mag;
    } nds_operand_t;

    // Queue entry.
    typedef struct packed {
        nds_tag_t     tag;
        nds_operand_t a;
        nds_operand_t b;
    } nds_qent_t;

    // Constant added after each Horner multiplication.
    function automatic logic signed [33:0] horner_add(input int k);
        logic signed [33:0] c;
        unique case (k)
            1: c = A4_Q30;
            2: c = A3_Q30;
            3: c = A2_Q30;
            4: c = A1_Q30;
            default: c = 34'sd0;
        endcase
        return c;
    endfunction

    // Signed Q30 product, truncated toward zero.
    function automatic logic signed [33:0] mul_q30(input logic signed [33:0] a,
                                                   input logic signed [33:0] b);
        logic signed [67:0] prod;
        logic signed [67:0] adj;
        prod = a * b;
        adj  = prod + (prod[67] ? 68'sd1073741823 : 68'sd0);
        return $signed(adj[63:30]);
    endfunction

endpackage

// ===== rtl/core/nds_queue.sv =====
// Short queue of classified words between the front and the evaluation lanes.
// Depends on nds_pkg for the entry type and depth.
module nds_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  nds_pkg::nds_qent_t  din,
    output logic                full,
    input  logic                pop,
    output logic                empty,
    output nds_pkg::nds_qent_t  dout
);

    nds_pkg::nds_qent_t                  mem [0:nds_pkg::QUEUE_DEPTH-1];
    logic [nds_pkg::QPTR_W-1:0]          wr_reg, wr_next;
    logic [nds_pkg::QPTR_W-1:0]          rd_reg, rd_next;
    logic [nds_pkg::QCNT_W-1:0]          cnt_reg, cnt_next;

    assign full  = (cnt_reg == nds_pkg::QCNT_W'(nds_pkg::QUEUE_DEPTH));
    assign empty = (cnt_reg == '0);
    assign dout  = mem[rd_reg];

    // Pointer and fill count update.
    always_comb begin
        wr_next  = push ? wr_reg + 1'b1 : wr_reg;
        rd_next  = pop  ? rd_reg + 1'b1 : rd_reg;
        cnt_next = cnt_reg + nds_pkg::QCNT_W'(push) - nds_pkg::QCNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    // Storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_reg] <= din;
        end
    end

endmodule

// ===== rtl/core/nds_front.sv =====
// Front end: accepts input words and classifies each operand against the mean.
// Depends on nds_pkg for the word and queue entry types.
module nds_front (
    input  logic                s_valid,
    output logic                s_ready,
    input  nds_pkg::nds_in_t    s_data,
    input  logic signed [31:0]  mean,
    input  logic                q_full,
    output logic                q_push,
    output nds_pkg::nds_qent_t  q_entry
);

    logic signed [32:0] diff_a;
    logic signed [32:0] diff_b;

    assign s_ready = !q_full;
    assign q_push  = s_valid && !q_full;

    // Distance of each bound to the mean, split into sign and magnitude.
    always_comb begin
        diff_a = 33'(s_data.x_or_lower) - 33'(mean);
        diff_b = 33'(s_data.upper_bound) - 33'(mean);
        q_entry.tag.op   = s_data.operation;
        q_entry.tag.last = s_data.last_in;
        q_entry.a.neg    = diff_a[32];
        q_entry.a.mag    = diff_a[32] ? 33'(-diff_a) : 33'(diff_a);
        q_entry.b.neg    = diff_b[32];
        q_entry.b.mag    = diff_b[32] ? 33'(-diff_b) : 33'(diff_b);
    end

endmodule

// ===== rtl/core/nds_lane.sv =====
// One evaluation lane: fully pipelined density or cumulative value of one operand.
// Depends on nds_pkg for types, constants and the Q30 multiply helper.
module nds_lane (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   adv,
    input  logic [31:0]            sig,
    input  logic                   in_valid,
    input  nds_pkg::nds_tag_t      in_tag,
    input  nds_pkg::nds_operand_t  in_opd,
    output logic                   out_valid,
    output nds_pkg::nds_tag_t      out_tag,
    output logic signed [33:0]     out_value
);

    // Stage positions along the lane.
    localparam int LAT   = 147;
    localparam int IX_U  = 31;
    localparam int IX_O  = 146;

    typedef struct packed {
        nds_pkg::nds_tag_t tag;
        logic              neg;
    } side_t;

    typedef struct packed {
        logic [32:0] mag;
        logic        big;
        logic [31:0] rem;
        logic [29:0] q;
    } zd_t;

    typedef struct packed {
        logic [31:0] w;
        logic [28:0] d;
        logic [28:0] rem;
        logic [30:0] q;
    } td_t;

    typedef struct packed {
        logic [31:0]        w;
        logic [30:0]        t;
        logic signed [33:0] poly;
    } hd_t;

    typedef struct packed {
        logic signed [33:0] poly;
        logic               zero;
        logic [37:0]        rem;
        logic [5:0]         k;
    } kd_t;

    typedef struct packed {
        logic signed [33:0] poly;
        logic               zero;
        logic [5:0]         k;
        logic [31:0]        r;
        logic [31:0]        x;
        logic [31:0]        q0;
        logic [33:0]        sum;
    } ed_t;

    typedef struct packed {
        logic [30:0]        p;
        logic signed [33:0] m;
        logic [31:0]        rem;
        logic [30:0]        q;
    } dd_t;

    logic  vld_reg  [0:LAT-1];
    side_t side_reg [0:LAT-1];

    zd_t                z_reg [0:30];
    logic [28:0]        zc_reg;
    logic [27:0]        u_reg;
    td_t                t_reg [0:31];
    hd_t                h_reg [1:5];
    kd_t                k_reg [0:6];
    ed_t                e_reg [0:36];
    logic signed [33:0] f_poly_reg;
    logic [32:0]        f_e_reg;
    dd_t                d_reg [0:31];
    logic signed [33:0] o_value_reg;

    // Valid and side information run alongside the data stages.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int n = 0; n < LAT; n++) begin
                vld_reg[n] <= 1'b0;
            end
        end else if (adv) begin
            vld_reg[0] <= in_valid;
            for (int n = 1; n < LAT; n++) begin
                vld_reg[n] <= vld_reg[n-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            side_reg[0].tag <= in_tag;
            side_reg[0].neg <= in_opd.neg;
            for (int n = 1; n < LAT; n++) begin
                side_reg[n] <= side_reg[n-1];
            end
        end
    end

    assign out_valid = vld_reg[IX_O];
    assign out_tag   = side_reg[IX_O].tag;
    assign out_value = o_value_reg;

    // |z| divider entry: flag quotients that clearly exceed the clamp.
    always_ff @(posedge aclk) begin
        if (adv) begin
            z_reg[0].mag <= in_opd.mag;
            z_reg[0].big <= ({5'b0, in_opd.mag} >= {sig, 6'b0});
            z_reg[0].rem <= {5'b0, in_opd.mag[32:6]};
            z_reg[0].q   <= '0;
        end
    end

    // |z| divider: one quotient bit of (mag << 24) / sigma per stage.
    for (genvar j = 1; j <= 30; j++) begin : g_zdiv
        localparam int B = 30 - j;
        logic        nbit;
        logic [32:0] r2;
        logic        ge;
        if (B >= 24) begin : g_num
            assign nbit = z_reg[j-1].mag[B-24];
        end else begin : g_zero
            assign nbit = 1'b0;
        end
        always_comb begin
            r2 = {z_reg[j-1].rem, nbit};
            ge = (r2 >= {1'b0, sig});
        end
        always_ff @(posedge aclk) begin
            if (adv) begin
                z_reg[j].mag <= z_reg[j-1].mag;
                z_reg[j].big <= z_reg[j-1].big;
                z_reg[j].rem <= ge ? 32'(r2 - {1'b0, sig}) : r2[31:0];
                z_reg[j].q   <= z_reg[j-1].q | (ge ? (30'd1 << B) : 30'd0);
            end
        end
    end

    // Clamp |z| and scale by 1/sqrt(2).
    logic [28:0] zc;
    logic [60:0] uprod;
    always_comb begin
        zc = (z_reg[30].big || (z_reg[30].q > nds_pkg::Z_CLAMP_Q24)) ?
             nds_pkg::Z_CLAMP_Q24[28:0] : z_reg[30].q[28:0];
        uprod = 61'(zc) * 61'(nds_pkg::INV_SQRT2_Q32);
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            zc_reg <= zc;
            u_reg  <= uprod[59:32];
        end
    end

    // Exponent argument and the divisor 1 + p*u for the erf polynomial.
    logic [57:0] zz;
    logic [55:0] uu;
    logic [59:0] pprod;
    logic        dens_w;
    always_comb begin
        zz     = 58'(zc_reg) * 58'(zc_reg);
        uu     = 56'(u_reg) * 56'(u_reg);
        pprod  = 60'(nds_pkg::P_Q32) * 60'(u_reg);
        dens_w = (side_reg[IX_U].tag.op == nds_pkg::OP_DENSITY);
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            t_reg[0].w   <= dens_w ? zz[56:25] : uu[55:24];
            t_reg[0].d   <= 29'd16777216 + 29'(pprod[58:32]);
            t_reg[0].rem <= 29'd8388608;
            t_reg[0].q   <= '0;
        end
    end

    // t divider: one quotient bit of 2^54 / (2^24 + p*u) per stage.
    for (genvar j = 1; j <= 31; j++) begin : g_tdiv
        localparam int B = 31 - j;
        logic [29:0] r2;
        logic        ge;
        always_comb begin
            r2 = {t_reg[j-1].rem, 1'b0};
            ge = (r2 >= {1'b0, t_reg[j-1].d});
        end
        always_ff @(posedge aclk) begin
            if (adv) begin
                t_reg[j].w   <= t_reg[j-1].w;
                t_reg[j].d   <= t_reg[j-1].d;
                t_reg[j].rem <= ge ? 29'(r2 - {1'b0, t_reg[j-1].d}) : r2[28:0];
                t_reg[j].q   <= t_reg[j-1].q | (ge ? (31'd1 << B) : 31'd0);
            end
        end
    end

    // Horner evaluation of the erf polynomial in t, one product per stage.
    for (genvar k = 1; k <= 5; k++) begin : g_horner
        logic signed [33:0] prev;
        logic [30:0]        t;
        logic [31:0]        w;
        if (k == 1) begin : g_first
            assign prev = nds_pkg::A5_Q30;
            assign t    = t_reg[31].q;
            assign w    = t_reg[31].w;
        end else begin : g_next
            assign prev = h_reg[k-1].poly;
            assign t    = h_reg[k-1].t;
            assign w    = h_reg[k-1].w;
        end
        always_ff @(posedge aclk) begin
            if (adv) begin
                h_reg[k].w    <= w;
                h_reg[k].t    <= t;
                h_reg[k].poly <= nds_pkg::mul_q30(prev, $signed({3'b0, t}))
                                 + nds_pkg::horner_add(k);
            end
        end
    end

    // Range reduction entry: exponents of 64*ln2 or more give zero.
    logic [39:0] w32;
    assign w32 = {h_reg[5].w, 8'b0};

    always_ff @(posedge aclk) begin
        if (adv) begin
            k_reg[0].poly <= h_reg[5].poly;
            k_reg[0].zero <= (w32 >= nds_pkg::LN2_X64);
            k_reg[0].rem  <= w32[37:0];
            k_reg[0].k    <= '0;
        end
    end

    // Range reduction: one bit of k = w / ln2 per stage.
    for (genvar j = 1; j <= 6; j++) begin : g_kdiv
        localparam int B = 6 - j;
        localparam logic [37:0] SUB = 38'(nds_pkg::LN2_Q32) << B;
        logic ge;
        assign ge = (k_reg[j-1].rem >= SUB);
        always_ff @(posedge aclk) begin
            if (adv) begin
                k_reg[j].poly <= k_reg[j-1].poly;
                k_reg[j].zero <= k_reg[j-1].zero;
                k_reg[j].rem  <= ge ? k_reg[j-1].rem - SUB : k_reg[j-1].rem;
                k_reg[j].k    <= k_reg[j-1].k | (ge ? (6'd1 << B) : 6'd0);
            end
        end
    end

    // First Taylor term of exp(-r) is r itself.
    always_ff @(posedge aclk) begin
        if (adv) begin
            e_reg[0].poly <= k_reg[6].poly;
            e_reg[0].zero <= k_reg[6].zero;
            e_reg[0].k    <= k_reg[6].k;
            e_reg[0].r    <= k_reg[6].rem[31:0];
            e_reg[0].x    <= k_reg[6].rem[31:0];
            e_reg[0].q0   <= '0;
            e_reg[0].sum  <= 34'h1_0000_0000 - 34'(k_reg[6].rem[31:0]);
        end
    end

    // Taylor terms two to thirteen: multiply by r, divide by the term index
    // through a reciprocal, then correct the quotient and accumulate.
    for (genvar s = 1; s <= 36; s++) begin : g_taylor
        localparam int          I     = 2 + (s - 1) / 3;
        localparam int          PH    = (s - 1) % 3;
        localparam logic [31:0] RECIP = 32'((64'd1 << 32) / I);
        localparam logic [3:0]  IDIV  = 4'(I);
        if (PH == 0) begin : g_mul_r
            logic [63:0] prod;
            ed_t         nxt;
            always_comb begin
                prod  = 64'(e_reg[s-1].x) * 64'(e_reg[s-1].r);
                nxt   = e_reg[s-1];
                nxt.x = prod[63:32];
            end
            always_ff @(posedge aclk) begin
                if (adv) begin
                    e_reg[s] <= nxt;
                end
            end
        end else if (PH == 1) begin : g_mul_recip
            logic [63:0] prod;
            ed_t         nxt;
            always_comb begin
                prod   = 64'(e_reg[s-1].x) * 64'(RECIP);
                nxt    = e_reg[s-1];
                nxt.q0 = prod[63:32];
            end
            always_ff @(posedge aclk) begin
                if (adv) begin
                    e_reg[s] <= nxt;
                end
            end
        end else begin : g_fix
            logic [35:0] back;
            logic [35:0] rest;
            logic [31:0] term;
            ed_t         nxt;
            always_comb begin
                back  = 36'(e_reg[s-1].q0) * 36'(IDIV);
                rest  = 36'(e_reg[s-1].x) - back;
                term  = (rest >= 36'(IDIV)) ? e_reg[s-1].q0 + 32'd1 : e_reg[s-1].q0;
                nxt   = e_reg[s-1];
                nxt.x = term;
                if ((I % 2) == 1) begin
                    nxt.sum = e_reg[s-1].sum - 34'(term);
                end else begin
                    nxt.sum = e_reg[s-1].sum + 34'(term);
                end
            end
            always_ff @(posedge aclk) begin
                if (adv) begin
                    e_reg[s] <= nxt;
                end
            end
        end
    end

    // Undo the range reduction.
    always_ff @(posedge aclk) begin
        if (adv) begin
            f_poly_reg <= e_reg[36].poly;
            f_e_reg    <= e_reg[36].zero ? 33'd0 : 33'(e_reg[36].sum >> e_reg[36].k);
        end
    end

    // Density numerator and erf product.
    logic [63:0] pprod_d;
    assign pprod_d = 64'(f_e_reg) * 64'(nds_pkg::INV_SQRT2PI_Q32);

    always_ff @(posedge aclk) begin
        if (adv) begin
            d_reg[0].p   <= pprod_d[62:32];
            d_reg[0].m   <= nds_pkg::mul_q30(f_poly_reg, $signed({3'b0, f_e_reg[32:2]}));
            d_reg[0].rem <= '0;
            d_reg[0].q   <= '0;
        end
    end

    // Density divider: one quotient bit of p / sigma per stage.
    for (genvar j = 1; j <= 31; j++) begin : g_ddiv
        localparam int B = 31 - j;
        logic [32:0] r2;
        logic        ge;
        always_comb begin
            r2 = {d_reg[j-1].rem, d_reg[j-1].p[B]};
            ge = (r2 >= {1'b0, sig});
        end
        always_ff @(posedge aclk) begin
            if (adv) begin
                d_reg[j].p   <= d_reg[j-1].p;
                d_reg[j].m   <= d_reg[j-1].m;
                d_reg[j].rem <= ge ? 32'(r2 - {1'b0, sig}) : r2[31:0];
                d_reg[j].q   <= d_reg[j-1].q | (ge ? (31'd1 << B) : 31'd0);
            end
        end
    end

    // Fold the sign back into the cumulative value, clamp and round to Q16.16.
    logic signed [35:0] num;
    logic signed [35:0] half;
    logic signed [35:0] clamped;
    logic signed [35:0] rounded;
    logic               dens_o;
    always_comb begin
        dens_o = (side_reg[IX_O-1].tag.op == nds_pkg::OP_DENSITY);
        num    = side_reg[IX_O-1].neg ? 36'(d_reg[31].m)
                                      : 36'sd2147483648 - 36'(d_reg[31].m);
        half   = (num + (num[35] ? 36'sd1 : 36'sd0)) >>> 1;
        if (half[35]) begin
            clamped = 36'sd0;
        end else if (half > 36'sd1073741824) begin
            clamped = 36'sd1073741824;
        end else begin
            clamped = half;
        end
        rounded = (clamped + 36'sd8192) >>> 14;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            o_value_reg <= dens_o ? $signed({3'b0, d_reg[31].q}) : 34'(rounded);
        end
    end

endmodule

// ===== rtl/core/normal_distribution_unit.sv =====
// Normal distribution unit: top level with configuration, front, queue and two lanes.
// Depends on nds_pkg, nds_front, nds_queue and nds_lane.
//
// Takes one word per clock and returns one result word per clock when the result
// side does not stall; each word passes through the queue, the 147 lane stages
// and the output register. Each lane is a single pipeline whose depth is set by
// its four bit-per-stage dividers (|z|, the erf t term, the range reduction and
// the density quotient) and the thirteen-term exponential series at three stages
// a term. Two lanes run side by side so an interval word costs no more than a
// point word. When the result is not taken the lanes hold and a four-entry queue
// keeps accepting.
module normal_distribution_unit #(
    parameter int DATA_WIDTH = nds_pkg::DATA_WIDTH_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  nds_pkg::nds_in_t   s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output nds_pkg::nds_out_t  m_data,
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [31:0]        cfg_wdata
);

    localparam int SAT_W = (DATA_WIDTH >= 32) ? 32 : DATA_WIDTH;
    localparam logic signed [33:0] SAT_HI = (34'sd1 <<< (SAT_W - 1)) - 34'sd1;
    localparam logic signed [33:0] SAT_LO = -SAT_HI - 34'sd1;

    logic signed [31:0] mean_reg;
    logic [31:0]        std_dev_reg;
    logic [31:0]        sig;

    logic               q_full;
    logic               q_push;
    logic               q_empty;
    logic               q_pop;
    nds_pkg::nds_qent_t q_din;
    nds_pkg::nds_qent_t q_dout;

    logic               adv;
    logic               a_valid;
    nds_pkg::nds_tag_t  a_tag;
    logic signed [33:0] a_value;
    logic signed [33:0] b_value;

    logic               m_valid_reg, m_valid_next;
    nds_pkg::nds_out_t  m_data_reg, m_data_next;
    logic signed [33:0] comb;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mean_reg    <= '0;
            std_dev_reg <= nds_pkg::STD_DEV_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                nds_pkg::REG_MEAN:    mean_reg    <= $signed(cfg_wdata);
                nds_pkg::REG_STD_DEV: std_dev_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // A zero deviation behaves as the smallest step.
    assign sig = (std_dev_reg == '0) ? 32'd1 : std_dev_reg;

    nds_front u_front (
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .mean    (mean_reg),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_entry (q_din)
    );

    nds_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .din     (q_din),
        .full    (q_full),
        .pop     (q_pop),
        .empty   (q_empty),
        .dout    (q_dout)
    );

    // The lanes move whenever the result register can take a word.
    assign adv   = !m_valid_reg || m_ready;
    assign q_pop = adv && !q_empty;

    nds_lane u_lane_a (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .sig       (sig),
        .in_valid  (!q_empty),
        .in_tag    (q_dout.tag),
        .in_opd    (q_dout.a),
        .out_valid (a_valid),
        .out_tag   (a_tag),
        .out_value (a_value)
    );

    nds_lane u_lane_b (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .sig       (sig),
        .in_valid  (!q_empty),
        .in_tag    (q_dout.tag),
        .in_opd    (q_dout.b),
        .out_valid (),
        .out_tag   (),
        .out_value (b_value)
    );

    // Select the result for the operation and saturate it.
    always_comb begin
        unique case (a_tag.op)
            nds_pkg::OP_DENSITY:  comb = a_value;
            nds_pkg::OP_CDF:      comb = a_value;
            nds_pkg::OP_INTERVAL: comb = b_value - a_value;
            default:              comb = 34'sd0;
        endcase
        if (comb > SAT_HI) begin
            m_data_next.value = 32'(SAT_HI);
        end else if (comb < SAT_LO) begin
            m_data_next.value = 32'(SAT_LO);
        end else begin
            m_data_next.value = 32'(comb);
        end
        m_data_next.last_out = a_tag.last;
        m_valid_next = adv ? a_valid : m_valid_reg;
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && a_valid) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ===== tb/tb_top.sv =====
// Testbench for the normal distribution unit: directed and random words over several
// mean and deviation settings, with a self-contained predictor and a result scoreboard.
// Depends on nds_pkg and normal_distribution_unit.
`timescale 1ns / 100ps

module tb_top;

    localparam int  LATENCY     = 148;
    localparam int  CYCLE_LIMIT = 400000;
    localparam int  RAND_WORDS  = 90;

    // Operation code that selects no mode.
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // Fixed-point constants of the evaluator, kept here at full width.
    localparam logic [63:0] K_LN2       = 64'd2977044472;
    localparam logic [63:0] K_INVSQRT2  = 64'd3037000500;
    localparam logic [63:0] K_INVSQ2PI  = 64'd1713444048;
    localparam logic [63:0] K_P         = 64'd1406993061;
    localparam logic [63:0] K_ZCLAMP    = 64'd16 << 24;
    localparam longint      K_ONE       = 64'sd1073741824;
    localparam longint      K_A1        = 64'sd273621191;
    localparam longint      K_A2        = -64'sd305476044;
    localparam longint      K_A3        = 64'sd1526231383;
    localparam longint      K_A4        = -64'sd1560310108;
    localparam longint      K_A5        = 64'sd1139675401;

    // Scoreboard: predicts each result and matches it against the result stream.
    class nds_scoreboard;
        longint            mean_q;
        logic [63:0]       sigma_q;
        nds_pkg::nds_out_t pending[$];
        int                mismatches;
        int                words_in;
        int                words_out;

        function new();
            mean_q     = 0;
            sigma_q    = 64'd65536;
            mismatches = 0;
            words_in   = 0;
            words_out  = 0;
        endfunction

        function logic [63:0] sigma_eff();
            return (sigma_q == 0) ? 64'd1 : sigma_q;
        endfunction

        // exp(-w) with w in Q.24, result in Q.32.
        function logic [63:0] exp_neg(logic [63:0] w24);
            logic [63:0] w32, k, r, sum, term;
            w32  = w24 << 8;
            k    = w32 / K_LN2;
            r    = w32 - k * K_LN2;
            sum  = 64'd1 << 32;
            term = 64'd1 << 32;
            for (int i = 1; i <= 13; i++) begin
                term = ((term * r) >> 32) / i;
                if (i % 2 == 1) sum = sum - term;
                else sum = sum + term;
            end
            if (k >= 64) return 64'd0;
            return sum >> k;
        endfunction

        // Distance to the mean in deviations, Q.24, clamped to 16.
        function logic [63:0] dist_z(logic signed [31:0] x, output bit below);
            longint      d;
            logic [63:0] ad, z;
            d     = longint'(x) - mean_q;
            ad    = (d < 0) ? 64'(-d) : 64'(d);
            z     = (ad << 24) / sigma_eff();
            below = d < 0;
            return (z > K_ZCLAMP) ? K_ZCLAMP : z;
        endfunction

        function longint mulq30(longint a, longint b);
            return (a * b) / K_ONE;
        endfunction

        function longint density(logic signed [31:0] x);
            bit          below;
            logic [63:0] z, e, p;
            z = dist_z(x, below);
            e = exp_neg((z * z) >> 25);
            p = (e * K_INVSQ2PI) >> 32;
            return longint'(p / sigma_eff());
        endfunction

        function longint cdf(logic signed [31:0] x);
            bit          below;
            logic [63:0] z, u, pu;
            longint      t, poly, e30, erf, c;
            z    = dist_z(x, below);
            u    = (z * K_INVSQRT2) >> 32;
            pu   = (K_P * u) >> 32;
            t    = longint'((64'd1 << 54) / ((64'd1 << 24) + pu));
            poly = K_A5;
            poly = mulq30(poly, t) + K_A4;
            poly = mulq30(poly, t) + K_A3;
            poly = mulq30(poly, t) + K_A2;
            poly = mulq30(poly, t) + K_A1;
            poly = mulq30(poly, t);
            e30  = longint'(exp_neg((u * u) >> 24) >> 2);
            erf  = K_ONE - mulq30(poly, e30);
            c    = below ? (K_ONE - erf) / 2 : (K_ONE + erf) / 2;
            if (c < 0) c = 0;
            if (c > K_ONE) c = K_ONE;
            return (c + 8192) / 16384;
        endfunction

        function void set_reg(logic idx, logic [31:0] data);
            if (idx == nds_pkg::REG_MEAN) mean_q = longint'(signed'(data));
            else sigma_q = 64'(data);
        endfunction

        // An input word was accepted: work out its result.
        function void note_word(nds_pkg::nds_in_t w);
            longint            v;
            nds_pkg::nds_out_t r;
            v = 0;
            case (w.operation)
                nds_pkg::OP_DENSITY:  v = density(w.x_or_lower);
                nds_pkg::OP_CDF:      v = cdf(w.x_or_lower);
                nds_pkg::OP_INTERVAL: v = cdf(w.upper_bound) - cdf(w.x_or_lower);
                default:              v = 0;
            endcase
            if (v > 64'sd2147483647) v = 64'sd2147483647;
            if (v < -64'sd2147483648) v = -64'sd2147483648;
            r.value    = v[31:0];
            r.last_out = w.last_in;
            pending.push_back(r);
            words_in++;
        endfunction

        task report_mismatch(string what, longint got, longint want);
            $display("MISMATCH %s: got %0d expected %0d (result %0d)", what, got, want,
                     words_out);
            mismatches++;
        endtask

        // A result word was accepted: compare it with the oldest prediction.
        task check_result(nds_pkg::nds_out_t got);
            nds_pkg::nds_out_t want;
            if (pending.size() == 0) begin
                report_mismatch("unexpected result", got.value, 0);
            end else begin
                want = pending.pop_front();
                if (got.value !== want.value)
                    report_mismatch("value", got.value, want.value);
                if (got.last_out !== want.last_out)
                    report_mismatch("last_out", got.last_out, want.last_out);
            end
            words_out++;
        endtask
    endclass

    logic              aclk;
    logic              aresetn;
    logic              s_valid;
    logic              s_ready;
    nds_pkg::nds_in_t  s_data;
    logic              m_valid;
    logic              m_ready;
    nds_pkg::nds_out_t m_data;
    logic              cfg_we;
    logic              cfg_index;
    logic [31:0]       cfg_wdata;

    nds_scoreboard sb;
    int            cycles;

    normal_distribution_unit u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk      = 1'b0;
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_data    = '0;
        m_ready   = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = nds_pkg::REG_MEAN;
        cfg_wdata = '0;
        cycles    = 0;
        sb        = new();
    end

    always #10 aclk = ~aclk;

    // Monitor both handshakes at the rising edge.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (aresetn && s_valid && s_ready) sb.note_word(s_data);
        if (aresetn && m_valid && m_ready) sb.check_result(m_data);
        if (cycles > CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles", cycles);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 19);
        if (r < 12) return 0;
        if (r < 18) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // The result side stalls at random, with quiet stretches of full readiness.
    initial begin
        int n;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            m_ready = 1'b1;
            n = ($urandom_range(0, 9) < 3) ? $urandom_range(20, 80) : $urandom_range(0, 6);
            repeat (n) @(negedge aclk);
            n = pick_gap();
            if (n > 0) begin
                m_ready = 1'b0;
                repeat (n - 1) @(negedge aclk);
            end
        end
    end

    task automatic write_reg(logic idx, logic [31:0] data);
        @(negedge aclk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_wdata = data;
        sb.set_reg(idx, data);
        @(negedge aclk);
        cfg_we = 1'b0;
    endtask

    // Offer one word and hold it until it is taken.
    task automatic send_word(logic [1:0] op, logic [31:0] xl, logic [31:0] ub, bit last);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid            = 1'b1;
        s_data.operation   = op;
        s_data.x_or_lower  = xl;
        s_data.upper_bound = ub;
        s_data.last_in     = last;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    task automatic wait_idle();
        @(negedge aclk);
        s_valid = 1'b0;
        while (sb.pending.size() != 0) @(negedge aclk);
        repeat (LATENCY + 20) @(negedge aclk);
    endtask

    // A point near the mean, scaled to the deviation, or anywhere at all.
    function automatic logic [31:0] pick_point();
        longint off;
        longint sd;
        if ($urandom_range(0, 3) == 0) return $urandom;
        sd  = (sb.sigma_q == 0) ? 1 : longint'(sb.sigma_q);
        off = (longint'($urandom_range(0, 12000)) - 6000) * sd / 1000;
        return 32'(sb.mean_q + off);
    endfunction

    task automatic random_phase(int count);
        logic [1:0] op;
        for (int i = 0; i < count; i++) begin
            op = ($urandom_range(0, 24) == 0) ? OP_UNUSED : 2'($urandom_range(0, 2));
            send_word(op, pick_point(), pick_point(), 1'($urandom_range(0, 1)));
        end
    endtask

    // Stimulus and end of run.
    initial begin
        logic [31:0] settings [6][2];
        settings[0] = '{32'h0000_0000, 32'h0001_0000};
        settings[1] = '{32'h0003_8000, 32'h0000_4000};
        settings[2] = '{32'h8000_0000, 32'hFFFF_FFFF};
        settings[3] = '{32'h7FFF_FFFF, 32'h0000_0001};
        settings[4] = '{32'hFFFE_0000, 32'h0000_0000};
        settings[5] = '{32'h0000_0000, 32'h0003_0000};

        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed words at reset settings: extremes, every operation, unused code.
        send_word(nds_pkg::OP_DENSITY,  32'h0000_0000, 32'h0, 1'b0);
        send_word(nds_pkg::OP_DENSITY,  32'h7FFF_FFFF, 32'h0, 1'b1);
        send_word(nds_pkg::OP_DENSITY,  32'h8000_0000, 32'h0, 1'b0);
        send_word(nds_pkg::OP_DENSITY,  32'h0001_0000, 32'hFFFF_FFFF, 1'b0);
        send_word(nds_pkg::OP_CDF,      32'h0000_0000, 32'h0, 1'b0);
        send_word(nds_pkg::OP_CDF,      32'h7FFF_FFFF, 32'h0, 1'b1);
        send_word(nds_pkg::OP_CDF,      32'h8000_0000, 32'h0, 1'b0);
        send_word(nds_pkg::OP_CDF,      32'hFFFF_0000, 32'h0, 1'b0);
        send_word(nds_pkg::OP_CDF,      32'h0010_0000, 32'h0, 1'b0);
        send_word(nds_pkg::OP_CDF,      32'h0011_0000, 32'h0, 1'b1);
        send_word(nds_pkg::OP_INTERVAL, 32'hFFFF_0000, 32'h0001_0000, 1'b0);
        send_word(nds_pkg::OP_INTERVAL, 32'h0001_0000, 32'hFFFF_0000, 1'b0);
        send_word(nds_pkg::OP_INTERVAL, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1);
        send_word(nds_pkg::OP_INTERVAL, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
        send_word(nds_pkg::OP_INTERVAL, 32'h0000_8000, 32'h0000_8000, 1'b0);
        send_word(OP_UNUSED,            32'h1234_5678, 32'h8765_4321, 1'b1);
        send_word(OP_UNUSED,            32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        random_phase(RAND_WORDS);

        // Further settings, the extremes and a zero deviation among them.
        for (int p = 0; p < 6; p++) begin
            wait_idle();
            write_reg(nds_pkg::REG_MEAN, settings[p][0]);
            write_reg(nds_pkg::REG_STD_DEV, settings[p][1]);
            send_word(nds_pkg::OP_CDF, settings[p][0], 32'h0, 1'b1);
            random_phase(RAND_WORDS);
        end

        @(negedge aclk);
        s_valid = 1'b0;
        while (sb.pending.size() != 0) @(negedge aclk);
        repeat (LATENCY + 50) @(negedge aclk);

        $display("Covered %0d words and %0d results over seven mean and deviation settings,",
                 sb.words_in, sb.words_out);
        $display("with all three modes, the unused code and random stalls on both sides.");
        if (sb.mismatches == 0 && sb.pending.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("%0d mismatches, %0d results missing", sb.mismatches, sb.pending.size());
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
